// ----- hdl/hte_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_pkg: shared types and constants
// Code table geometry, request kinds and the run handed from packer to buffer.
// ----------------------------------------------------------------------------
package hte_pkg;

   localparam int MAX_CODE_LEN = 32;
   localparam int SYMBOLS      = 256;

   localparam int CODE_W   = 32;
   localparam int LEN_W    = 6;
   localparam int LEN_CAP  = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam int ADDR_W   = $clog2(SYMBOLS);
   localparam int PEND_W   = 7;
   localparam int PCNT_W   = 3;
   localparam int ACC_W    = PEND_W + CODE_W;
   localparam int RUN_BYTES = 4;
   localparam int RUN_W    = 8 * RUN_BYTES;
   localparam int RCNT_W   = 3;

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_ENCODE = 2'd1,
      KIND_FLUSH  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
   } entry_type;

   typedef struct packed {
      logic [RUN_W-1:0]  bytes;   // first byte in the top lane
      logic [RCNT_W-1:0] count;
   } run_type;

endpackage

// ----- hdl/hte_code_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_code_table: code table memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hte_code_table (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [hte_pkg::ADDR_W-1:0] wr_addr,
   input  hte_pkg::entry_type         wr_entry,
   input  logic                       rd_en,
   input  logic [hte_pkg::ADDR_W-1:0] rd_addr,
   output hte_pkg::entry_type         rd_entry
);

   hte_pkg::entry_type mem [hte_pkg::SYMBOLS];
   hte_pkg::entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ----- hdl/hte_bit_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_bit_packer: lookup stage and pending bit accumulator
// Merges the looked-up code with pending bits and cuts whole bytes.
// ----------------------------------------------------------------------------
module hte_bit_packer (
   input  logic               clock,
   input  logic               reset,
   input  logic               issue,
   input  hte_pkg::kind_type  issue_kind,
   input  logic               issue_sym_ok,
   input  hte_pkg::entry_type entry,
   input  logic               buf_free,
   output logic               take_ready,
   output logic               run_load,
   output hte_pkg::run_type   run
);

   logic                        s1_valid_ff, s1_valid_in;
   hte_pkg::kind_type           s1_kind_ff;
   logic                        s1_sym_ok_ff;
   logic [hte_pkg::PEND_W-1:0]  pending_bits_ff, pending_bits_in;
   logic [hte_pkg::PCNT_W-1:0]  pending_count_ff, pending_count_in;

   logic                        fire;
   logic                        needs_buf;
   logic [hte_pkg::LEN_W-1:0]   len_eff;
   logic [hte_pkg::CODE_W-1:0]  code_eff;
   logic [hte_pkg::ACC_W-1:0]   acc;
   logic [hte_pkg::ACC_W-1:0]   aligned;
   logic [hte_pkg::LEN_W-1:0]   total;
   logic [hte_pkg::LEN_W-1:0]   lshift;
   logic [hte_pkg::PCNT_W-1:0]  rem;
   logic [hte_pkg::PEND_W-1:0]  rem_mask;
   logic [7:0]                  flush_byte;

   assign needs_buf  = (s1_kind_ff == hte_pkg::KIND_ENCODE) ||
                       (s1_kind_ff == hte_pkg::KIND_FLUSH);
   assign fire       = s1_valid_ff && (buf_free || !needs_buf);
   assign take_ready = !s1_valid_ff || fire;
   assign s1_valid_in = issue || (s1_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         pending_bits_ff  <= '0;
         pending_count_ff <= '0;
      end else begin
         s1_valid_ff      <= s1_valid_in;
         pending_bits_ff  <= pending_bits_in;
         pending_count_ff <= pending_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_kind_ff   <= issue_kind;
         s1_sym_ok_ff <= issue_sym_ok;
      end
   end

   // merge: pending bits sit above the new code
   always_comb begin
      len_eff  = s1_sym_ok_ff ? entry.len : '0;
      code_eff = s1_sym_ok_ff ? entry.code : '0;
      acc      = (hte_pkg::ACC_W'(pending_bits_ff) << len_eff) |
                 hte_pkg::ACC_W'(code_eff);
      total    = hte_pkg::LEN_W'(pending_count_ff) + len_eff;
      lshift   = hte_pkg::LEN_W'(hte_pkg::ACC_W) - total;
      aligned  = acc << lshift;
      rem      = total[hte_pkg::PCNT_W-1:0];
      rem_mask = (hte_pkg::PEND_W'(1) << rem) - hte_pkg::PEND_W'(1);
      flush_byte = 8'(pending_bits_ff) << (4'd8 - 4'(pending_count_ff));
   end

   always_comb begin
      pending_bits_in  = pending_bits_ff;
      pending_count_in = pending_count_ff;
      run.bytes        = '0;
      run.count        = '0;
      case (s1_kind_ff)
         hte_pkg::KIND_ENCODE: begin
            run.bytes = aligned[hte_pkg::ACC_W-1 -: hte_pkg::RUN_W];
            run.count = total[hte_pkg::LEN_W-1:3];
            if (fire) begin
               pending_bits_in  = acc[hte_pkg::PEND_W-1:0] & rem_mask;
               pending_count_in = rem;
            end
         end
         hte_pkg::KIND_FLUSH: begin
            run.bytes = {flush_byte, {(hte_pkg::RUN_W-8){1'b0}}};
            run.count = (pending_count_ff != '0) ? hte_pkg::RCNT_W'(1) : '0;
            if (fire) begin
               pending_bits_in  = '0;
               pending_count_in = '0;
            end
         end
         default: begin
            run.count = '0;
         end
      endcase
   end

   assign run_load = fire && (run.count != '0);

   assert property (@(posedge clock) disable iff (reset)
      (pending_bits_ff & ~((hte_pkg::PEND_W'(1) << pending_count_ff)
                            - hte_pkg::PEND_W'(1))) == '0)
      else $error("pending bits set above the pending count");

   assert property (@(posedge clock) disable iff (reset)
      (fire && s1_kind_ff == hte_pkg::KIND_FLUSH) |=> (pending_count_ff == '0))
      else $error("flush left bits pending");

endmodule

// ----- hdl/hte_out_buffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_out_buffer: response byte buffer
// Holds one run of up to four bytes and sends them out one a cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module hte_out_buffer (
   input  logic             clock,
   input  logic             reset,
   input  logic             run_load,
   input  hte_pkg::run_type run,
   output logic             buf_free,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_of_run
);

   logic [hte_pkg::RUN_W-1:0]  bytes_ff, bytes_in;
   logic [hte_pkg::RCNT_W-1:0] count_ff, count_in;
   logic                       take;

   assign rsp_valid       = (count_ff != '0);
   assign take            = rsp_valid && rsp_ready;
   assign buf_free        = (count_ff == '0) ||
                            (count_ff == hte_pkg::RCNT_W'(1) && rsp_ready);
   assign rsp_out_byte    = bytes_ff[hte_pkg::RUN_W-1 -: 8];
   assign rsp_last_of_run = (count_ff == hte_pkg::RCNT_W'(1));

   always_comb begin
      bytes_in = bytes_ff;
      count_in = count_ff;
      if (run_load) begin
         bytes_in = run.bytes;
         count_in = run.count;
      end else if (take) begin
         bytes_in = bytes_ff << 8;
         count_in = count_ff - hte_pkg::RCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      run_load |-> (count_ff == '0 || (count_ff == hte_pkg::RCNT_W'(1) && take)))
      else $error("run loaded over unsent bytes");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= hte_pkg::RCNT_W'(hte_pkg::RUN_BYTES))
      else $error("buffer count beyond run size");

endmodule

// ----- hdl/huffman_table_encoder_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_table_encoder_packer: table-driven Huffman encoder with byte packer
// Loads codes into a table, encodes data bytes MSB-first, flushes the tail.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_ready   kind, symbol, code_bits, code_length
//   rsp_     out        rsp_valid / rsp_ready   out_byte, last_of_run
//
// A request is accepted at the edge where req_valid and req_ready are high.
// The table read is issued at that edge; the merge stage then merges the code
// with the pending bits and hands up to four bytes to the response buffer once
// it is free, and the buffer sends one byte a cycle while rsp_ready is high.
// Requests that make at most one byte sustain one request per cycle while
// rsp_ready is high; a request that makes n bytes holds the next encode or
// flush until its run has drained. Reset clears the pending bits and the
// pipeline; the code table keeps its contents and is undefined until loaded.
// A stalled response stalls the merge stage and then req_ready.
//
module huffman_table_encoder_packer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_symbol,
   input  logic [31:0] req_code_bits,
   input  logic [5:0]  req_code_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run
);

   logic                       req_take;
   hte_pkg::kind_type          kind;
   logic                       sym_ok;
   logic [hte_pkg::ADDR_W-1:0] addr;
   logic [hte_pkg::LEN_W-1:0]  load_len;
   logic [hte_pkg::CODE_W:0]   load_mask;
   hte_pkg::entry_type         wr_entry;
   hte_pkg::entry_type         rd_entry;
   logic                       wr_en;
   logic                       rd_en;
   logic                       buf_free;
   logic                       run_load;
   hte_pkg::run_type           run;

   assign req_take = req_valid && req_ready;
   assign kind     = hte_pkg::kind_type'(req_kind);
   // drop symbols beyond the table
   assign sym_ok   = ({1'b0, req_symbol} < 9'(hte_pkg::SYMBOLS));
   assign addr     = req_symbol[hte_pkg::ADDR_W-1:0];

   // saturate the length and keep only the low code bits
   always_comb begin
      load_len = req_code_length;
      if (req_code_length > hte_pkg::LEN_W'(hte_pkg::LEN_CAP)) begin
         load_len = hte_pkg::LEN_W'(hte_pkg::LEN_CAP);
      end
      load_mask     = ((hte_pkg::CODE_W + 1)'(1) << load_len) - (hte_pkg::CODE_W + 1)'(1);
      wr_entry.code = req_code_bits & load_mask[hte_pkg::CODE_W-1:0];
      wr_entry.len  = load_len;
   end

   // a load writes at its accept edge, so any later encode reads the new entry
   assign wr_en = req_take && (kind == hte_pkg::KIND_LOAD) && sym_ok;
   assign rd_en = req_take && (kind == hte_pkg::KIND_ENCODE);

   hte_code_table u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (addr),
      .wr_entry (wr_entry),
      .rd_en    (rd_en),
      .rd_addr  (addr),
      .rd_entry (rd_entry)
   );

   hte_bit_packer u_packer (
      .clock        (clock),
      .reset        (reset),
      .issue        (req_take),
      .issue_kind   (kind),
      .issue_sym_ok (sym_ok),
      .entry        (rd_entry),
      .buf_free     (buf_free),
      .take_ready   (req_ready),
      .run_load     (run_load),
      .run          (run)
   );

   hte_out_buffer u_buffer (
      .clock           (clock),
      .reset           (reset),
      .run_load        (run_load),
      .run             (run),
      .buf_free        (buf_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ----- dv/huffman_table_encoder_packer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_table_encoder_packer_tb: self-checking bench for the Huffman packer
// Loads code table entries, encodes bytes and flushes the tail, predicting
// every packed byte and its end-of-run flag, with random idling on both sides.
// ----------------------------------------------------------------------------
module huffman_table_encoder_packer_tb;

   localparam time CLK_PERIOD     = 20ns;
   localparam int  RESET_CYCLES   = 7;
   localparam int  RANDOM_ITEMS   = 500;
   localparam int  QUIET_FROM     = 420;   // no idling from this request on
   localparam int  PRESS_FROM     = 150;   // long response hold-off starts here
   localparam int  PRESS_ITEMS    = 60;    // back-to-back requests during it
   localparam int  HOLD_OFF       = 400;
   localparam int  WATCHDOG_LIMIT = 3000;
   localparam int  DRAIN_CYCLES   = 32;
   localparam int  MAX_REPORTS    = 10;

   // Request kind that the block ignores
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   // Expected byte count meaning "ask the predictor"
   localparam int FROM_PREDICTOR = -1;

   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  symbol;
      logic [31:0] code_bits;
      logic [5:0]  code_length;
      int          n_typed;     // FROM_PREDICTOR or the typed byte count
      logic [31:0] typed_run;   // typed bytes, first byte in the top lane
   } request_type;

   typedef struct {
      logic [7:0] out_byte;
      logic       last;
   } packed_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_kind = KIND_UNUSED;
   logic [7:0]  req_symbol = '0;
   logic [31:0] req_code_bits = '0;
   logic [5:0]  req_code_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_run;

   // Predictor state: its own copy of the code table and the bit accumulator
   hte_pkg::entry_type         code_mem [hte_pkg::SYMBOLS];
   bit                         loaded   [hte_pkg::SYMBOLS];
   logic [7:0]                 loaded_syms [$];
   logic [hte_pkg::PEND_W-1:0] pend_bits = '0;
   logic [hte_pkg::PCNT_W-1:0] pend_cnt  = '0;

   packed_byte_type expected_bytes [$];
   request_type     directed_rows  [$];

   int  mismatch_count = 0;
   int  bytes_checked  = 0;
   int  loads = 0, encodes = 0, flushes = 0, ignored = 0, full_runs = 0;
   bit  quiet = 1'b0;          // suppress idling on both sides
   bit  hold_off_req = 1'b0;   // ask the receiver for the long hold-off
   bit  hold_off_done = 1'b0;

   huffman_table_encoder_packer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_symbol      (req_symbol),
      .req_code_bits   (req_code_bits),
      .req_code_length (req_code_length),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Work out the bytes one request produces and advance the packer state.
   // Bytes come back in run, first byte in the top lane, n of them.
   task automatic pack_predict(input logic [1:0] kind, input logic [7:0] sym,
                               input logic [31:0] bits, input logic [5:0] len_in,
                               output int n, output logic [31:0] run);
      int          len;
      int          total;
      logic [63:0] acc;
      logic [63:0] mask;
      logic [7:0]  tail;
      n   = 0;
      run = '0;
      case (kind)
         hte_pkg::KIND_LOAD: begin
            // Saturate an overlong length and keep only the low code bits
            len = int'(len_in);
            if (len > hte_pkg::LEN_CAP) len = hte_pkg::LEN_CAP;
            mask = (64'd1 << len) - 64'd1;
            code_mem[sym].code = bits & mask[31:0];
            code_mem[sym].len  = hte_pkg::LEN_W'(len);
            if (!loaded[sym]) begin
               loaded[sym] = 1'b1;
               loaded_syms.push_back(sym);
            end
         end
         hte_pkg::KIND_ENCODE: begin
            len = int'(code_mem[sym].len);
            // An empty code appends nothing
            if (len != 0) begin
               acc   = ({57'd0, pend_bits} << len) | {32'd0, code_mem[sym].code};
               total = int'(pend_cnt) + len;
               while (total >= 8 && n < hte_pkg::RUN_BYTES) begin
                  run[31 - 8 * n -: 8] = acc[total - 1 -: 8];
                  n++;
                  total -= 8;
               end
               mask      = (64'd1 << total) - 64'd1;
               pend_bits = acc[hte_pkg::PEND_W-1:0] & mask[hte_pkg::PEND_W-1:0];
               pend_cnt  = hte_pkg::PCNT_W'(total);
            end
         end
         hte_pkg::KIND_FLUSH: begin
            // Pad the partial byte with zeros in its low bits
            if (pend_cnt != 0) begin
               tail        = {1'b0, pend_bits};
               run[31:24]  = tail << (8 - int'(pend_cnt));
               n           = 1;
               pend_bits   = '0;
               pend_cnt    = '0;
            end
         end
         default: ;
      endcase
   endtask

   task automatic add_row(input logic [1:0] kind, input logic [7:0] sym,
                          input logic [31:0] bits, input logic [5:0] len,
                          input int n_typed, input logic [31:0] typed_run);
      request_type r;
      r.kind        = kind;
      r.symbol      = sym;
      r.code_bits   = bits;
      r.code_length = len;
      r.n_typed     = n_typed;
      r.typed_run   = typed_run;
      directed_rows.push_back(r);
   endtask

   // Present one request, hold it until accepted, then queue what it owes.
   // Valid is left high; the caller lowers it only when a gap follows.
   task automatic send_request(input request_type r);
      int              n;
      logic [31:0]     run;
      packed_byte_type pb;
      req_valid       <= 1'b1;
      req_kind        <= r.kind;
      req_symbol      <= r.symbol;
      req_code_bits   <= r.code_bits;
      req_code_length <= r.code_length;
      do @(posedge clock); while (!req_ready);
      pack_predict(r.kind, r.symbol, r.code_bits, r.code_length, n, run);
      if (r.n_typed != FROM_PREDICTOR) begin
         n   = r.n_typed;
         run = r.typed_run;
      end
      for (int i = 0; i < n; i++) begin
         pb.out_byte = run[31 - 8 * i -: 8];
         pb.last     = (i == n - 1);
         expected_bytes.push_back(pb);
      end
      if (n == hte_pkg::RUN_BYTES) full_runs++;
      case (r.kind)
         hte_pkg::KIND_LOAD:   loads++;
         hte_pkg::KIND_ENCODE: encodes++;
         hte_pkg::KIND_FLUSH:  flushes++;
         default:              ignored++;
      endcase
   endtask

   // Drop valid for a random burst; scramble the idle payload while at it
   task automatic sender_gap();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid       <= 1'b0;
         req_kind        <= 2'($urandom);
         req_symbol      <= 8'($urandom);
         req_code_bits   <= $urandom;
         req_code_length <= 6'($urandom);
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   function automatic request_type random_request();
      request_type r;
      int          pick;
      int          lsel;
      r.n_typed     = FROM_PREDICTOR;
      r.typed_run   = '0;
      r.kind        = hte_pkg::KIND_ENCODE;
      r.symbol      = 8'($urandom);
      r.code_bits   = $urandom;
      r.code_length = 6'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
         r.kind = hte_pkg::KIND_LOAD;
         // Mostly short codes, some long ones, a few overlong or empty
         lsel = $urandom_range(0, 9);
         if (lsel <= 5)      r.code_length = 6'($urandom_range(1, 10));
         else if (lsel <= 7) r.code_length = 6'($urandom_range(11, 32));
         else if (lsel == 8) r.code_length = 6'($urandom_range(33, 63));
         else                r.code_length = '0;
      end else if (pick < 82) begin
         // Encode only symbols whose entry has been loaded
         r.symbol = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
      end else if (pick < 95) begin
         r.kind = hte_pkg::KIND_FLUSH;
      end else begin
         r.kind = KIND_UNUSED;
      end
      return r;
   endfunction

   // Receiver: random stall bursts, plus one long hold-off counted here
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare each accepted byte with the oldest expectation
   always @(posedge clock) begin
      packed_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         bytes_checked++;
         if (expected_bytes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected byte %02h last %0b", $realtime,
                        rsp_out_byte, rsp_last_of_run);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte || rsp_last_of_run !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: byte mismatch: expected %02h last %0b, got %02h last %0b",
                           $realtime, want.out_byte, want.last,
                           rsp_out_byte, rsp_last_of_run);
            end
         end
      end
   end

   // Watchdog: end the run after too many cycles without any handshake
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d bytes outstanding",
                     idle_cycles, expected_bytes.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      int          counted;
      request_type r;

      // Directed rows; typed results only where they are obvious
      add_row(hte_pkg::KIND_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  0, 32'h0);  // nothing pending
      add_row(KIND_UNUSED,          8'hFF, 32'hFFFF_FFFF, 6'd63, 0, 32'h0);
      add_row(hte_pkg::KIND_LOAD,   8'hFF, 32'h0000_00A5, 6'd8,  0, 32'h0);
      add_row(hte_pkg::KIND_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd32, 0, 32'h0);
      add_row(hte_pkg::KIND_ENCODE, 8'hFF, 32'h0,         6'd0,  1, 32'hA500_0000);
      add_row(hte_pkg::KIND_ENCODE, 8'h00, 32'h0,         6'd0,  4, 32'hFFFF_FFFF);
      add_row(hte_pkg::KIND_LOAD,   8'h02, 32'hFFFF_FFFD, 6'd3,  0, 32'h0);  // high bits dropped
      add_row(hte_pkg::KIND_ENCODE, 8'h02, 32'h0,         6'd0,  0, 32'h0);
      add_row(hte_pkg::KIND_FLUSH,  8'h00, 32'h0,         6'd0,  1, 32'hA000_0000);
      add_row(hte_pkg::KIND_LOAD,   8'h03, 32'hFFFF_FFFF, 6'd0,  0, 32'h0);  // empty code
      add_row(hte_pkg::KIND_ENCODE, 8'h03, 32'h0,         6'd0,  0, 32'h0);
      add_row(hte_pkg::KIND_FLUSH,  8'h00, 32'h0,         6'd0,  0, 32'h0);
      add_row(hte_pkg::KIND_LOAD,   8'h04, 32'h0000_0001, 6'd1,  0, 32'h0);
      add_row(hte_pkg::KIND_ENCODE, 8'h04, 32'h0,         6'd0,  FROM_PREDICTOR, 32'h0);
      add_row(hte_pkg::KIND_LOAD,   8'h01, 32'hFFFF_FFFF, 6'd63, 0, 32'h0);  // overlong length
      add_row(hte_pkg::KIND_ENCODE, 8'h01, 32'h0,         6'd0,  FROM_PREDICTOR, 32'h0);
      add_row(hte_pkg::KIND_FLUSH,  8'h00, 32'h0,         6'd0,  FROM_PREDICTOR, 32'h0);
      add_row(hte_pkg::KIND_LOAD,   8'h05, 32'h0000_007F, 6'd7,  0, 32'h0);
      add_row(hte_pkg::KIND_ENCODE, 8'h05, 32'h0,         6'd0,  FROM_PREDICTOR, 32'h0);
      add_row(hte_pkg::KIND_ENCODE, 8'h05, 32'h0,         6'd0,  FROM_PREDICTOR, 32'h0);
      add_row(hte_pkg::KIND_FLUSH,  8'h00, 32'h0,         6'd0,  FROM_PREDICTOR, 32'h0);
      add_row(hte_pkg::KIND_LOAD,   8'h06, 32'h0000_0000, 6'd32, 0, 32'h0);
      add_row(hte_pkg::KIND_ENCODE, 8'h06, 32'h0,         6'd0,  4, 32'h0000_0000);
      add_row(hte_pkg::KIND_LOAD,   8'h07, 32'h1234_5678, 6'd40, 0, 32'h0);  // saturates to 32
      add_row(hte_pkg::KIND_ENCODE, 8'h07, 32'h0,         6'd0,  4, 32'h1234_5678);
      add_row(KIND_UNUSED,          8'hFF, 32'h0000_0000, 6'd5,  0, 32'h0);  // must not load
      add_row(hte_pkg::KIND_ENCODE, 8'hFF, 32'h0,         6'd0,  1, 32'hA500_0000);

      // Hold reset, then release it at an edge
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i]);
         sender_gap();
      end

      // Random part; ignored kinds do not count toward the total
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         r = random_request();
         if (counted == PRESS_FROM) hold_off_req = 1'b1;
         quiet = (counted >= QUIET_FROM);
         send_request(r);
         if (r.kind != KIND_UNUSED) counted++;
         // Keep offering back to back while the receiver holds off
         if (counted < PRESS_FROM || counted >= PRESS_FROM + PRESS_ITEMS)
            sender_gap();
      end
      req_valid <= 1'b0;

      // Wait for the last bytes, then watch a little longer for strays
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d loads, %0d encodes, %0d flushes, %0d ignored requests",
               loads, encodes, flushes, ignored);
      $display("checked %0d bytes, %0d four-byte runs, one long response hold-off",
               bytes_checked, full_runs);
      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/hte_pkg.sv
hdl/hte_code_table.sv
hdl/hte_bit_packer.sv
hdl/hte_out_buffer.sv
hdl/huffman_table_encoder_packer.sv
dv/huffman_table_encoder_packer_tb.sv
